>>> sv/fsks_pkg.sv
// ----------------------------------------------------------------------------
// Fan stall supervisor package
// Shared types, register indexes, reset values and the duty mapping.
// ----------------------------------------------------------------------------
package fsks_pkg;

    localparam int TIME_BITS_DEFAULT = 32;
    localparam int CFG_ADDR_BITS     = 3;
    localparam int CFG_DATA_BITS     = 16;

    typedef enum logic [1:0] {
        OP_TICK               = 2'd0,
        OP_SET_INTAKE         = 2'd1,
        OP_SET_INTAKE_MASKED  = 2'd2,
        OP_SET_EXHAUST        = 2'd3
    } op_t;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_MIN_INTAKE_DUTY      = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_MASK_TIME            = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_CHECK_PERIOD         = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_KICK_DURATION        = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_TOGGLE_PERIOD        = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_SAMPLE_WINDOW        = 3'd5;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_EXHAUST_CHECK_ENABLE = 3'd6;

    localparam logic [7:0]  RST_MIN_INTAKE_DUTY = 8'd64;
    localparam logic [15:0] RST_MASK_TIME       = 16'd3000;
    localparam logic [15:0] RST_CHECK_PERIOD    = 16'd1000;
    localparam logic [15:0] RST_KICK_DURATION   = 16'd700;
    localparam logic [15:0] RST_TOGGLE_PERIOD   = 16'd80;
    localparam logic [7:0]  RST_SAMPLE_WINDOW   = 8'd10;

    localparam logic [15:0] COMPARE_FULL_ON = 16'h0000;
    localparam logic [15:0] COMPARE_OFF     = 16'hFFFF;
    localparam logic [7:0]  DUTY_FULL       = 8'd255;

    typedef struct packed {
        logic tick;
        logic kick_restart;
        logic load;
    } drive_ctl_t;

    // (255 - d) * 257 is the inverted duty repeated in both bytes.
    function automatic logic [15:0] duty_to_compare(input logic [7:0] d);
        return {~d, ~d};
    endfunction

endpackage

>>> sv/fsks_if.sv
// ----------------------------------------------------------------------------
// Fan stall supervisor channel interfaces
// Command, result and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface fsks_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] duty;
    logic       tach_a_pulse;
    logic       tach_b_pulse;
    logic       tach_exhaust_pulse;

    modport source (output valid, op, duty, tach_a_pulse, tach_b_pulse,
                    tach_exhaust_pulse, input ready);
    modport sink   (input valid, op, duty, tach_a_pulse, tach_b_pulse,
                    tach_exhaust_pulse, output ready);
endinterface

interface fsks_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] intake_compare;
    logic [15:0] exhaust_compare;
    logic [7:0]  intake_reported_duty;
    logic        intake_failed;
    logic        exhaust_failed;

    modport source (output valid, intake_compare, exhaust_compare,
                    intake_reported_duty, intake_failed, exhaust_failed,
                    input ready);
    modport sink   (input valid, intake_compare, exhaust_compare,
                    intake_reported_duty, intake_failed, exhaust_failed,
                    output ready);
endinterface

interface fsks_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [fsks_pkg::CFG_ADDR_BITS-1:0] addr;
    logic [fsks_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

>>> sv/fsks_fan_drive.sv
// ----------------------------------------------------------------------------
// Fan drive with stall kick
// Holds one fan's compare value and runs the on/off toggling after a stall.
// ----------------------------------------------------------------------------
module fsks_fan_drive #(
    parameter int TIME_BITS = fsks_pkg::TIME_BITS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fsks_pkg::drive_ctl_t ctl,
    input  logic [TIME_BITS-1:0] tnow,
    input  logic [15:0]          kick_duration,
    input  logic [15:0]          toggle_period,
    input  logic [15:0]          normal,
    output logic [15:0]          compare_next
);

    logic [TIME_BITS-1:0] kick_start_reg;
    logic [TIME_BITS-1:0] kick_start_next;
    logic [TIME_BITS-1:0] toggle_start_reg;
    logic [TIME_BITS-1:0] toggle_start_next;
    logic                 phase_reg;
    logic                 phase_next;
    logic [15:0]          compare_reg;
    logic [TIME_BITS-1:0] kick_since;
    logic [TIME_BITS-1:0] toggle_since;
    logic                 kicking;

    assign kick_since   = ctl.kick_restart ? '0 : tnow - kick_start_reg;
    assign toggle_since = tnow - toggle_start_reg;
    assign kicking      = kick_since < TIME_BITS'(kick_duration);

    always_comb
    begin
        kick_start_next   = ctl.kick_restart ? tnow : kick_start_reg;
        toggle_start_next = toggle_start_reg;
        phase_next        = phase_reg;
        compare_next      = compare_reg;
        if (ctl.load)
        begin
            compare_next = normal;
        end
        else if (ctl.tick)
        begin
            if (kicking)
            begin
                if (toggle_since > TIME_BITS'(toggle_period))
                begin
                    toggle_start_next = tnow;
                    phase_next        = !phase_reg;
                    compare_next      = phase_reg ? fsks_pkg::COMPARE_OFF
                                                  : fsks_pkg::COMPARE_FULL_ON;
                end
            end
            else
            begin
                phase_next   = 1'b1;
                compare_next = normal;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kick_start_reg   <= '0;
            toggle_start_reg <= '0;
            phase_reg        <= 1'b0;
            compare_reg      <= '0;
        end
        else if (ctl.tick || ctl.load)
        begin
            kick_start_reg   <= kick_start_next;
            toggle_start_reg <= toggle_start_next;
            phase_reg        <= phase_next;
            compare_reg      <= compare_next;
        end
    end

endmodule

>>> sv/fan_stall_kick_supervisor_top.sv
// ----------------------------------------------------------------------------
// Fan stall kick supervisor
// Drives an intake fan pair and an exhaust fan, checks their tachometers and
// kicks a stalled fan by toggling its drive between full on and off.
// ----------------------------------------------------------------------------
// Usage:
// The item channel takes millisecond ticks with tachometer pulse flags and
// duty commands. Every item produces exactly one transfer on the result
// channel with both timer compare values, the reported intake duty and the
// two failure flags as they stand after the item.
// Each item is first captured in an input register and is then worked off
// into the result register, from which its result is offered; while the
// receiver stalls, the item waits in the input register. One item is
// accepted per cycle sustained while the receiver does not stall; the update
// of the timing and window state as each item is worked off sets that rate.
// When the receiver stalls, the result register holds and the input register
// takes one more item; item ready then drops until the result is taken.
// Register writes on the cfg channel are always accepted and should be done
// while no item is in flight.
// Reset clears all timers, windows and duties, sets both compare values to
// full on and loads the default register values.
// ----------------------------------------------------------------------------
module fan_stall_kick_supervisor_top #(
    parameter int TIME_BITS = fsks_pkg::TIME_BITS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    fsks_in_if.sink    item,
    fsks_out_if.source result,
    fsks_cfg_if.sink   cfg
);

    // Configuration registers.
    logic [7:0]  min_intake_duty_reg;
    logic [15:0] mask_time_reg;
    logic [15:0] check_period_reg;
    logic [15:0] kick_duration_reg;
    logic [15:0] toggle_period_reg;
    logic [7:0]  sample_window_reg;
    logic        exhaust_check_enable_reg;

    // Input register.
    logic            s1_valid_reg;
    fsks_pkg::op_t   s1_op_reg;
    logic [7:0]      s1_duty_reg;
    logic [2:0]      s1_pulses_reg;

    // Result register.
    logic        out_valid_reg;
    logic [15:0] out_intake_compare_reg;
    logic [15:0] out_exhaust_compare_reg;
    logic [7:0]  out_reported_duty_reg;
    logic        out_intake_failed_reg;
    logic        out_exhaust_failed_reg;

    // Supervisor state.
    logic [TIME_BITS-1:0] now_reg;
    logic [TIME_BITS-1:0] now_inc_reg;
    logic [TIME_BITS-1:0] last_check_reg;
    logic [TIME_BITS-1:0] last_check_next;
    logic [7:0]           window_left_reg;
    logic [7:0]           window_left_next;
    logic                 window_exhaust_reg;
    logic                 window_exhaust_next;
    logic [2:0]           flags_reg;
    logic [2:0]           flags_next;
    logic                 intake_spin_reg;
    logic                 intake_spin_next;
    logic                 exhaust_spin_reg;
    logic                 exhaust_spin_next;
    logic [7:0]           intake_duty_reg;
    logic [7:0]           intake_duty_next;
    logic [7:0]           exhaust_duty_reg;
    logic [7:0]           exhaust_duty_next;
    logic [TIME_BITS-1:0] mask_intake_start_reg;
    logic [TIME_BITS-1:0] mask_exhaust_start_reg;

    logic                 advance;
    logic                 in_ready;
    logic                 fire;
    logic                 is_tick;
    logic                 is_set_intake;
    logic                 is_set_exhaust;
    logic                 mask_intake_restart;
    logic                 mask_exhaust_restart;
    logic [TIME_BITS-1:0] tnow;
    logic [TIME_BITS-1:0] mask_intake_since;
    logic [TIME_BITS-1:0] mask_exhaust_since;
    logic                 intake_masked;
    logic                 exhaust_masked;
    logic                 intake_kick;
    logic                 exhaust_kick;
    logic [7:0]           intake_applied_duty;
    logic [15:0]          intake_normal;
    logic [15:0]          exhaust_normal;
    logic [15:0]          intake_compare_next;
    logic [15:0]          exhaust_compare_next;
    logic [7:0]           reported_duty_next;
    logic                 intake_failed_next;
    logic                 exhaust_failed_next;
    logic [2:0]           flags_merged;

    fsks_pkg::drive_ctl_t intake_ctl;
    fsks_pkg::drive_ctl_t exhaust_ctl;

    // Handshake.
    assign advance   = !out_valid_reg || result.ready;
    assign in_ready  = !s1_valid_reg || advance;
    assign fire      = s1_valid_reg && advance;
    assign item.ready = in_ready;
    assign cfg.ready  = 1'b1;

    assign result.valid                = out_valid_reg;
    assign result.intake_compare       = out_intake_compare_reg;
    assign result.exhaust_compare      = out_exhaust_compare_reg;
    assign result.intake_reported_duty = out_reported_duty_reg;
    assign result.intake_failed        = out_intake_failed_reg;
    assign result.exhaust_failed       = out_exhaust_failed_reg;

    assign is_tick        = fire && (s1_op_reg == fsks_pkg::OP_TICK);
    assign is_set_intake  = fire && ((s1_op_reg == fsks_pkg::OP_SET_INTAKE)
                                  || (s1_op_reg == fsks_pkg::OP_SET_INTAKE_MASKED));
    assign is_set_exhaust = fire && (s1_op_reg == fsks_pkg::OP_SET_EXHAUST);

    // A tick sees the incremented time; commands take no time.
    assign tnow = (s1_op_reg == fsks_pkg::OP_TICK) ? now_inc_reg : now_reg;

    assign flags_merged = flags_reg | s1_pulses_reg;

    always_comb
    begin
        last_check_next     = last_check_reg;
        window_left_next    = window_left_reg;
        window_exhaust_next = window_exhaust_reg;
        flags_next          = flags_reg;
        intake_spin_next    = intake_spin_reg;
        exhaust_spin_next   = exhaust_spin_reg;
        intake_kick         = 1'b0;
        exhaust_kick        = 1'b0;
        if (s1_op_reg == fsks_pkg::OP_TICK)
        begin
            if (window_left_reg != 8'd0)
            begin
                flags_next       = flags_merged;
                window_left_next = window_left_reg - 8'd1;
                if (window_left_reg == 8'd1)
                begin
                    intake_spin_next  = (flags_merged[1:0] == 2'b11);
                    exhaust_spin_next = flags_merged[2];
                    intake_kick       = !intake_spin_next && (intake_duty_reg != 8'd0);
                    exhaust_kick      = window_exhaust_reg && !exhaust_spin_next;
                end
            end
            else if ((tnow - last_check_reg) > TIME_BITS'(check_period_reg))
            begin
                last_check_next     = tnow;
                window_left_next    = (sample_window_reg == 8'd0) ? 8'd1 : sample_window_reg;
                flags_next          = 3'b000;
                window_exhaust_next = exhaust_check_enable_reg && (exhaust_duty_reg != 8'd0);
            end
        end
    end

    assign intake_duty_next  = is_set_intake ? s1_duty_reg : intake_duty_reg;
    assign exhaust_duty_next = is_set_exhaust ? s1_duty_reg : exhaust_duty_reg;

    assign intake_applied_duty = ((intake_duty_next != 8'd0)
                                  && (intake_duty_next < min_intake_duty_reg))
                                 ? min_intake_duty_reg : intake_duty_next;
    assign intake_normal  = fsks_pkg::duty_to_compare(intake_applied_duty);
    assign exhaust_normal = fsks_pkg::duty_to_compare(exhaust_duty_reg);

    assign intake_ctl.tick          = is_tick;
    assign intake_ctl.kick_restart  = is_tick && intake_kick;
    assign intake_ctl.load          = is_set_intake;
    assign exhaust_ctl.tick         = is_tick;
    assign exhaust_ctl.kick_restart = is_tick && exhaust_kick;
    assign exhaust_ctl.load         = 1'b0;

    fsks_fan_drive #(
        .TIME_BITS (TIME_BITS)
    ) u_intake_drive (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (intake_ctl),
        .tnow          (tnow),
        .kick_duration (kick_duration_reg),
        .toggle_period (toggle_period_reg),
        .normal        (intake_normal),
        .compare_next  (intake_compare_next)
    );

    fsks_fan_drive #(
        .TIME_BITS (TIME_BITS)
    ) u_exhaust_drive (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (exhaust_ctl),
        .tnow          (tnow),
        .kick_duration (kick_duration_reg),
        .toggle_period (toggle_period_reg),
        .normal        (exhaust_normal),
        .compare_next  (exhaust_compare_next)
    );

    // Failure masks.
    assign mask_intake_restart  = s1_op_reg == fsks_pkg::OP_SET_INTAKE_MASKED;
    assign mask_exhaust_restart = (s1_op_reg == fsks_pkg::OP_SET_EXHAUST)
                                  && (exhaust_duty_reg != s1_duty_reg);
    assign mask_intake_since  = mask_intake_restart ? '0 : tnow - mask_intake_start_reg;
    assign mask_exhaust_since = mask_exhaust_restart ? '0 : tnow - mask_exhaust_start_reg;
    assign intake_masked  = mask_intake_since < TIME_BITS'(mask_time_reg);
    assign exhaust_masked = mask_exhaust_since < TIME_BITS'(mask_time_reg);

    always_comb
    begin
        if (intake_masked || intake_spin_next)
        begin
            reported_duty_next = intake_duty_next;
        end
        else
        begin
            reported_duty_next = 8'd0;
        end
        intake_failed_next  = !intake_masked && !intake_spin_next
                              && (intake_duty_next != 8'd0);
        exhaust_failed_next = !exhaust_masked
                              && (exhaust_spin_next ? (exhaust_duty_next != fsks_pkg::DUTY_FULL)
                                                    : (exhaust_duty_next != 8'd0));
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_intake_duty_reg      <= fsks_pkg::RST_MIN_INTAKE_DUTY;
            mask_time_reg            <= fsks_pkg::RST_MASK_TIME;
            check_period_reg         <= fsks_pkg::RST_CHECK_PERIOD;
            kick_duration_reg        <= fsks_pkg::RST_KICK_DURATION;
            toggle_period_reg        <= fsks_pkg::RST_TOGGLE_PERIOD;
            sample_window_reg        <= fsks_pkg::RST_SAMPLE_WINDOW;
            exhaust_check_enable_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.addr)
                fsks_pkg::CFG_MIN_INTAKE_DUTY:      min_intake_duty_reg      <= cfg.data[7:0];
                fsks_pkg::CFG_MASK_TIME:            mask_time_reg            <= cfg.data;
                fsks_pkg::CFG_CHECK_PERIOD:         check_period_reg         <= cfg.data;
                fsks_pkg::CFG_KICK_DURATION:        kick_duration_reg        <= cfg.data;
                fsks_pkg::CFG_TOGGLE_PERIOD:        toggle_period_reg        <= cfg.data;
                fsks_pkg::CFG_SAMPLE_WINDOW:        sample_window_reg        <= cfg.data[7:0];
                fsks_pkg::CFG_EXHAUST_CHECK_ENABLE: exhaust_check_enable_reg <= cfg.data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && item.valid)
        begin
            s1_op_reg     <= fsks_pkg::op_t'(item.op);
            s1_duty_reg   <= item.duty;
            s1_pulses_reg <= {item.tach_exhaust_pulse, item.tach_b_pulse, item.tach_a_pulse};
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_intake_compare_reg  <= intake_compare_next;
            out_exhaust_compare_reg <= exhaust_compare_next;
            out_reported_duty_reg   <= reported_duty_next;
            out_intake_failed_reg   <= intake_failed_next;
            out_exhaust_failed_reg  <= exhaust_failed_next;
        end
    end

    // Supervisor state update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg                <= '0;
            now_inc_reg            <= TIME_BITS'(1);
            last_check_reg         <= '0;
            window_left_reg        <= '0;
            window_exhaust_reg     <= 1'b0;
            flags_reg              <= '0;
            intake_spin_reg        <= 1'b0;
            exhaust_spin_reg       <= 1'b0;
            intake_duty_reg        <= '0;
            exhaust_duty_reg       <= '0;
            mask_intake_start_reg  <= '0;
            mask_exhaust_start_reg <= '0;
        end
        else
        begin
            if (is_tick)
            begin
                now_reg            <= now_inc_reg;
                now_inc_reg        <= now_inc_reg + TIME_BITS'(1);
                last_check_reg     <= last_check_next;
                window_left_reg    <= window_left_next;
                window_exhaust_reg <= window_exhaust_next;
                flags_reg          <= flags_next;
                intake_spin_reg    <= intake_spin_next;
                exhaust_spin_reg   <= exhaust_spin_next;
            end
            if (is_set_intake)
            begin
                intake_duty_reg <= intake_duty_next;
            end
            if (is_set_exhaust)
            begin
                exhaust_duty_reg <= exhaust_duty_next;
            end
            if (fire && mask_intake_restart)
            begin
                mask_intake_start_reg <= tnow;
            end
            if (fire && mask_exhaust_restart)
            begin
                mask_exhaust_start_reg <= tnow;
            end
        end
    end

    // Assertions.
    a_now_inc_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        now_inc_reg == now_reg + TIME_BITS'(1))
        else $error("Incremented time copy lost track of the millisecond clock.");

    a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> ($stable(now_reg) && $stable(window_left_reg)))
        else $error("Supervisor state moved while the result register was stalled.");

    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg && !result.ready))
        else $error("Item channel stalled although a register was free.");

    a_window_open_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (!is_tick) |=> $stable(window_left_reg))
        else $error("Sample window changed without a tick.");

endmodule
